// File: sv/cbgf_pkg.sv
// ----------------------------------------------------------------------------
// cbgf_pkg: shared types and constants for the color blob feature block
// Frame statistics record and divider control types.
// ----------------------------------------------------------------------------
package cbgf_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned CRD_W   = 10;
  localparam int unsigned AREA_W  = 21;
  localparam int unsigned PERIM_W = 20;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEP_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [CRD_W-1:0] BOX_MIN_INIT = '1;

  // Accumulated frame statistics handed to the divider sequencer.
  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perim;
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [CRD_W-1:0]   min_row;
    logic [CRD_W-1:0]   max_row;
    logic [CRD_W-1:0]   min_col;
    logic [CRD_W-1:0]   max_col;
  } frame_stats_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DCOL = 4'b0010,
    ST_DROW = 4'b0100,
    ST_OUT  = 4'b1000
  } seq_state_t;

endpackage

// File: sv/cbgf_ram.sv
// ----------------------------------------------------------------------------
// cbgf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cbgf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cbgf_div.sv
// ----------------------------------------------------------------------------
// cbgf_div: restoring divider
// One quotient bit per cycle; quotient truncated to the coordinate width.
// ----------------------------------------------------------------------------
module cbgf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cbgf_pkg::SUM_W-1:0]  dividend,
  input  logic [cbgf_pkg::AREA_W-1:0] divisor,
  output logic                        done,
  output logic [cbgf_pkg::CRD_W-1:0]  quotient
);

  localparam int unsigned SW = cbgf_pkg::SUM_W;
  localparam int unsigned RW = cbgf_pkg::AREA_W + 1;

  logic [SW-1:0]       q_r;
  logic [RW-1:0]       rem_r;
  logic [RW-1:0]       dvs_r;
  logic [cbgf_pkg::DIV_STEP_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [RW-1:0]       trial;
  logic [RW:0]         diff;

  assign trial = {rem_r[RW-2:0], q_r[SW-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= cbgf_pkg::DIV_STEP_W'(SW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= {1'b0, divisor};
    end else if (busy_r) begin
      if (!diff[RW]) begin
        rem_r <= diff[RW-1:0];
        q_r   <= {q_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[SW-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r[cbgf_pkg::CRD_W-1:0];

endmodule

// File: sv/cbgf_accum.sv
// ----------------------------------------------------------------------------
// cbgf_accum: per-pixel mask, window and frame accumulators
// Classifies each pixel, tracks raster position and updates statistics.
// ----------------------------------------------------------------------------
module cbgf_accum #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pix_valid,
  input  logic [cbgf_pkg::COLOR_W-1:0] pix,
  input  logic [cbgf_pkg::COLOR_W-1:0] target,
  input  logic [cbgf_pkg::SIZE_W-1:0]  fwidth,
  input  logic [cbgf_pkg::SIZE_W-1:0]  fheight,
  output logic                         frame_end,
  output cbgf_pkg::frame_stats_t       stats
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (AW > $clog2(MAX_HEIGHT)) ? AW : $clog2(MAX_HEIGHT);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned CRD = cbgf_pkg::CRD_W;

  logic [CW-1:0] col_r, row_r;
  logic [8:0]    win_r;
  logic [1:0]    lb_rd;
  logic [DW-1:0] w_cl, h_cl;
  logic          cur, last_col, last_row;
  logic [8:0]    win_nxt;
  cbgf_pkg::frame_stats_t st_r;
  logic [CRD-1:0] c10, r10;

  // line buffers: bit0 row r-1, bit1 row r-2 (registered read)
  cbgf_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (pix_valid),
    .waddr (col_r[AW-1:0]),
    .wdata ({lb_rd[0], cur}),
    .raddr (col_r[AW-1:0]),
    .rdata (lb_rd)
  );

  always_comb begin
    w_cl = (fwidth < 11'd3) ? DW'(3) :
           ({{(DW > 11 ? DW-11 : 0){1'b0}}, fwidth} > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH)
           : DW'(fwidth);
    h_cl = (fheight < 11'd3) ? DW'(3) :
           ({{(DW > 11 ? DW-11 : 0){1'b0}}, fheight} > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT)
           : DW'(fheight);
    cur      = (pix == target);
    last_col = ({1'b0, col_r} >= w_cl - 1'b1);
    last_row = ({1'b0, row_r} >= h_cl - 1'b1);
    win_nxt  = {win_r[5:0], lb_rd[1], lb_rd[0], cur};
    c10      = CRD'(col_r);
    r10      = CRD'(row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
      st_r  <= '{default: '0, min_row: cbgf_pkg::BOX_MIN_INIT,
                 min_col: cbgf_pkg::BOX_MIN_INIT};
    end else if (pix_valid) begin
      if (last_col && last_row) begin
        // frame done: clear for next frame, stats leave via frame_end snapshot
        col_r <= '0;
        row_r <= '0;
        win_r <= '0;
        st_r  <= '{default: '0, min_row: cbgf_pkg::BOX_MIN_INIT,
                   min_col: cbgf_pkg::BOX_MIN_INIT};
      end else begin
        win_r <= win_nxt;
        st_r  <= stats;
        if (!last_col) begin
          col_r <= col_r + 1'b1;
        end else begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

  // final statistics including the last pixel
  always_comb begin
    stats = st_r;
    if (row_r >= CW'(2) && col_r >= CW'(2) && win_nxt[4] && win_nxt != 9'h1FF) begin
      stats.perim = st_r.perim + 1'b1;
    end
    if (cur) begin
      stats.area    = st_r.area + 1'b1;
      stats.col_sum = st_r.col_sum + cbgf_pkg::SUM_W'(col_r);
      stats.row_sum = st_r.row_sum + cbgf_pkg::SUM_W'(row_r);
      if (r10 < st_r.min_row) stats.min_row = r10;
      if (r10 > st_r.max_row) stats.max_row = r10;
      if (c10 < st_r.min_col) stats.min_col = c10;
      if (c10 > st_r.max_col) stats.max_col = c10;
    end
  end

  assign frame_end = pix_valid && last_col && last_row;

  a_col_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(frame_end) |-> (col_r == '0 && row_r == '0 && st_r.area == '0))
    else $error("counters not cleared after frame end");
  a_win_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && !frame_end) |=> win_r[8:3] == $past(win_r[5:0]))
    else $error("window did not shift");
  a_area_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (!pix_valid) |=> $stable(st_r.area))
    else $error("area moved without a pixel");

endmodule

// File: sv/color_blob_geometric_features.sv
// ----------------------------------------------------------------------------
// color_blob_geometric_features: area, perimeter, centroid and box of a blob
// Top level: handshakes, configuration registers, frame-end sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one 24-bit pixel per transfer in raster order.
//   A pixel matching target_color is object. Per frame the block counts area,
//   perimeter pixels, column/row sums and bounding box.
//   Each pixel is first held while the line-buffer RAM is read, then used
//   for the update (the RAM's registered read port sets this), so a new
//   pixel is taken only once the last one is through. After the last pixel
//   of a frame the shared restoring divider runs twice (centroid column,
//   then row), and the result is offered on out_valid.
//   The input stays stalled until the result transfers; a stalled receiver
//   holds the whole block. Empty frames skip the divider.
//   cfg_valid/cfg_ready write register cfg_index (0 target, 1 width,
//   2 height); cfg_ready is always high. Reset (rst_n low, synchronous)
//   restores default registers and clears counters; line buffer content
//   is undefined until written.
// ----------------------------------------------------------------------------
module color_blob_geometric_features #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cbgf_pkg::COLOR_W-1:0]   in_pixel_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cbgf_pkg::AREA_W-1:0]    out_area,
  output logic [cbgf_pkg::PERIM_W-1:0]   out_perimeter_length,
  output logic [cbgf_pkg::CRD_W-1:0]     out_centroid_col,
  output logic [cbgf_pkg::CRD_W-1:0]     out_centroid_row,
  output logic [cbgf_pkg::CRD_W-1:0]     out_min_row,
  output logic [cbgf_pkg::CRD_W-1:0]     out_max_row,
  output logic [cbgf_pkg::CRD_W-1:0]     out_min_col,
  output logic [cbgf_pkg::CRD_W-1:0]     out_max_col,
  output logic                           out_object_empty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbgf_pkg::COLOR_W-1:0]   cfg_data
);

  logic [cbgf_pkg::COLOR_W-1:0] target_r;
  logic [cbgf_pkg::SIZE_W-1:0]  width_r, height_r;
  logic [cbgf_pkg::COLOR_W-1:0] pix_r;
  logic                         pix_pend_r;
  logic                         frame_end;
  cbgf_pkg::frame_stats_t       stats, res_r;
  cbgf_pkg::seq_state_t         state_r, state_nxt;
  logic                         div_start, div_done;
  logic [cbgf_pkg::SUM_W-1:0]   div_num;
  logic [cbgf_pkg::CRD_W-1:0]   div_q, ccol_r, crow_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      width_r  <= 11'd640;
      height_r <= 11'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbgf_pkg::REG_TARGET: target_r <= cfg_data;
        cbgf_pkg::REG_WIDTH:  width_r  <= cfg_data[cbgf_pkg::SIZE_W-1:0];
        cbgf_pkg::REG_HEIGHT: height_r <= cfg_data[cbgf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the pixel while the line buffers are read
  assign in_ready = (state_r == cbgf_pkg::ST_IDLE) && !pix_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_pend_r <= 1'b0;
    end else begin
      pix_pend_r <= in_valid && in_ready;
    end
    if (in_valid && in_ready) pix_r <= in_pixel_color;
  end

  cbgf_accum #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_pend_r),
    .pix       (pix_r),
    .target    (target_r),
    .fwidth    (width_r),
    .fheight   (height_r),
    .frame_end (frame_end),
    .stats     (stats)
  );

  assign div_num = (state_r == cbgf_pkg::ST_IDLE) ? stats.col_sum : res_r.row_sum;
  assign div_start = (frame_end && stats.area != '0) ||
                     (state_r == cbgf_pkg::ST_DCOL && div_done);

  cbgf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  ((state_r == cbgf_pkg::ST_IDLE) ? stats.area : res_r.area),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbgf_pkg::ST_IDLE: if (frame_end) begin
        state_nxt = (stats.area != '0) ? cbgf_pkg::ST_DCOL : cbgf_pkg::ST_OUT;
      end
      cbgf_pkg::ST_DCOL: if (div_done) state_nxt = cbgf_pkg::ST_DROW;
      cbgf_pkg::ST_DROW: if (div_done) state_nxt = cbgf_pkg::ST_OUT;
      cbgf_pkg::ST_OUT:  if (out_ready) state_nxt = cbgf_pkg::ST_IDLE;
      default:           state_nxt = cbgf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbgf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (frame_end) begin
      res_r  <= stats;
      ccol_r <= '0;
      crow_r <= '0;
    end
    if (state_r == cbgf_pkg::ST_DCOL && div_done) ccol_r <= div_q;
    if (state_r == cbgf_pkg::ST_DROW && div_done) crow_r <= div_q;
  end

  assign out_valid            = (state_r == cbgf_pkg::ST_OUT);
  assign out_object_empty     = (res_r.area == '0);
  assign out_area             = res_r.area;
  assign out_perimeter_length = out_object_empty ? '0 : res_r.perim;
  assign out_centroid_col     = ccol_r;
  assign out_centroid_row     = crow_r;
  assign out_min_row          = out_object_empty ? '0 : res_r.min_row;
  assign out_max_row          = out_object_empty ? '0 : res_r.max_row;
  assign out_min_col          = out_object_empty ? '0 : res_r.min_col;
  assign out_max_col          = out_object_empty ? '0 : res_r.max_col;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cbgf_pkg::ST_IDLE) |-> !in_ready)
    else $error("input accepted while sequencer busy");
  a_empty_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_end && stats.area == '0) |=> out_valid)
    else $error("empty frame did not go straight to output");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == cbgf_pkg::ST_DCOL || state_r == cbgf_pkg::ST_DROW))
    else $error("divider finished outside a divide state");

endmodule
